// File: sv/fdt_pkg.sv
// Shared types and constants for the truncating single-precision divider.
package fdt_pkg;
   localparam int unsigned SigWidth  = 24;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned CntWidth  = 5;
   localparam logic [ExpWidth-1:0] ExpMax = 8'hFF;
   localparam logic [9:0] Bias = 10'd127;

   typedef struct packed {
      logic load;   // capture operands and begin
      logic step;   // one quotient bit
      logic pack;   // normalise and form result
   } cmd_type;

   typedef struct packed {
      logic bypass; // special case settled at load
   } status_type;
endpackage

// File: sv/float32_divider_truncating.sv
// Top level of the truncating single-precision divider.
// From the input beat: operands load, 24 divide steps run, then a pack step
// writes the output register and the result turns valid. Requests are
// accepted only in IDLE, after the last result is taken. The restoring
// divider gives one bit per cycle. Synchronous active-high reset idles it.
module float32_divider_truncating (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_dividend_bits,
   input  logic [31:0] req_divisor_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_quotient_bits
);
   import fdt_pkg::*;

   cmd_type    cmd;
   status_type status;

   fdt_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .status
   );

   fdt_datapath u_dp (
      .clock, .cmd, .status,
      .dividend_bits(req_dividend_bits),
      .divisor_bits(req_divisor_bits),
      .result(rsp_quotient_bits)
   );
endmodule

// File: sv/fdt_datapath.sv
// Datapath: operand unpack, restoring divider and result packing.
module fdt_datapath (
   input  logic                clock,
   input  fdt_pkg::cmd_type    cmd,
   output fdt_pkg::status_type status,
   input  logic [31:0]         dividend_bits,
   input  logic [31:0]         divisor_bits,
   output logic [31:0]         result
);
   import fdt_pkg::*;

   logic [SigWidth:0]   rem_ff, rem_in;
   logic [SigWidth-1:0] den_ff;
   logic [SigWidth-1:0] num_ff, num_in;
   logic [SigWidth-1:0] q_ff, q_in;
   logic [9:0]          er_ff;
   logic                sign_ff, bypass_ff;
   logic [31:0]         byp_res_ff, res_ff;
   logic [ExpWidth-1:0] ea, eb;
   logic                sgn, nan_inf, zero_b, zero_a;
   logic [SigWidth:0]   trial;
   logic [SigWidth-1:0] qn;
   logic [9:0]          ern;

   assign ea = dividend_bits[30:23];
   assign eb = divisor_bits[30:23];
   assign sgn = dividend_bits[31] ^ divisor_bits[31];
   assign nan_inf = (ea == ExpMax) || (eb == ExpMax);
   assign zero_b = (divisor_bits[30:0] == 31'd0);
   assign zero_a = (dividend_bits[30:0] == 31'd0);

   // Dividend is sig<<23: the top 24 bits feed in first, then 23 zeros.
   // Start remainder with the top sig bits already consumed, leaving 24 steps.
   assign trial = {rem_ff[SigWidth-1:0], num_ff[SigWidth-1]} - {1'b0, den_ff};

   always_comb begin
      rem_in = {rem_ff[SigWidth-1:0], num_ff[SigWidth-1]};
      q_in   = {q_ff[SigWidth-2:0], 1'b0};
      if (!trial[SigWidth]) begin
         rem_in = trial;
         q_in[0] = 1'b1;
      end
      num_in = {num_ff[SigWidth-2:0], 1'b0};
   end

   // Quotient lies in [2^22, 2^24): at most one left shift.
   always_comb begin
      qn  = q_ff;
      ern = er_ff;
      if (!q_ff[SigWidth-1] && !er_ff[9] && (er_ff != 10'd0)) begin
         qn  = {q_ff[SigWidth-2:0], 1'b0};
         ern = er_ff - 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         // The 23 leading dividend bits lie below the divisor and give only zero
         // quotient bits, so instead of starting at remainder 0 and shifting in all
         // 24 significand bits, we preload rem with the top 23 bits.
         rem_ff    <= {2'b00, 1'b1, dividend_bits[22:1]};
         num_ff    <= {dividend_bits[0], {FracWidth{1'b0}}};
         den_ff    <= {1'b1, divisor_bits[22:0]};
         q_ff      <= '0;
         er_ff     <= {2'b00, ea} - {2'b00, eb} + Bias;
         sign_ff   <= sgn;
         bypass_ff <= nan_inf || zero_b || zero_a;
         byp_res_ff <= (nan_inf || zero_b) ? {sgn, ExpMax, {FracWidth{1'b0}}}
                                           : {sgn, 31'd0};
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         q_ff   <= q_in;
      end
      if (cmd.pack) begin
         if (bypass_ff)
            res_ff <= byp_res_ff;
         else if (!ern[9] && (ern >= 10'd255))
            res_ff <= {sign_ff, ExpMax, {FracWidth{1'b0}}};
         else if (ern[9] || (ern == 10'd0))
            res_ff <= {sign_ff, 31'd0};
         else
            res_ff <= {sign_ff, ern[ExpWidth-1:0], qn[FracWidth-1:0]};
      end
   end

   assign status.bypass = bypass_ff;
   assign result = res_ff;
endmodule

// File: sv/fdt_control.sv
// Controller: sequences load, 24 divide steps, pack and result handshake.
module fdt_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fdt_pkg::cmd_type cmd,
   input  fdt_pkg::status_type status
);
   import fdt_pkg::*;

   typedef enum logic [1:0] {IDLE, DIVIDE, PACK, DONE} state_type;
   state_type state_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic                unused_bypass;

   assign unused_bypass = status.bypass;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == DONE);
   assign cmd.load = req_valid && req_ready;
   assign cmd.step = (state_ff == DIVIDE);
   assign cmd.pack = (state_ff == PACK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               cnt_ff <= '0;
               if (req_valid) state_ff <= DIVIDE;
            end
            DIVIDE: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CntWidth'(SigWidth - 1)) state_ff <= PACK;
            end
            PACK: state_ff <= DONE;
            DONE: if (rsp_ready) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// File: sv/fdt_checker.sv
// Port-level checker for the divider, bound to the top level.
module fdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_quotient_bits
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accepting while result pending");
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too soon");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_quotient_bits))
      else $error("stalled result changed");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready) else $error("not idle after beat");
endmodule

bind float32_divider_truncating fdt_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_quotient_bits
);
